/* src/hcb_pkg.sv */
package hcb_pkg;

    // Field and register widths
    localparam int SYM_W       = 5;
    localparam int DIM_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int MAX_DIM_DEF = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 3'd0;
    localparam int                   CFG_KEY0 = 1;

    // mod 26 by reciprocal: q = (x * RECIP) >> RECIP_SH
    localparam int MODULUS  = 26;
    localparam int RECIP_W  = 12;
    localparam int RECIP    = 2521;
    localparam int RECIP_SH = 16;

    // Microprogram addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MAC   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd2;
    localparam logic [STEP_W-1:0] STEP_QUOT  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;

    typedef struct packed {
        logic [SYM_W-1:0] plain_symbol;
        logic             end_of_message;
    } t_in;

    typedef struct packed {
        logic [SYM_W-1:0] cipher_symbol;
        logic             block_last;
    } t_out;

    typedef enum logic [1:0] {
        H_NONE = 2'd0,
        H_IN   = 2'd1,
        H_OUT  = 2'd2
    } t_hold;

    typedef enum logic [1:0] {
        C_NEVER   = 2'd0,
        C_NOBLK   = 2'd1,
        C_MORECOL = 2'd2,
        C_MOREROW = 2'd3
    } t_cond;

    typedef struct packed {
        t_hold             hold;
        logic              mac;
        logic              acc_add;
        logic              quot;
        logic              emit;
        t_cond             cond;
        logic [STEP_W-1:0] tgt;
        logic [STEP_W-1:0] nxt;
    } t_uword;

    typedef struct packed {
        logic load;
        logic clr;
        logic mac;
        logic acc_add;
        logic quot;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic blk_done;
        logic more_col;
        logic more_row;
    } t_stat;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_IDLE:  w = '{H_IN,   1'b0, 1'b0, 1'b0, 1'b0, C_NOBLK,   STEP_IDLE, STEP_MAC};
            STEP_MAC:   w = '{H_NONE, 1'b1, 1'b1, 1'b0, 1'b0, C_MORECOL, STEP_MAC,  STEP_DRAIN};
            STEP_DRAIN: w = '{H_NONE, 1'b0, 1'b1, 1'b0, 1'b0, C_NEVER,   STEP_IDLE, STEP_QUOT};
            STEP_QUOT:  w = '{H_NONE, 1'b0, 1'b0, 1'b1, 1'b0, C_NEVER,   STEP_IDLE, STEP_EMIT};
            STEP_EMIT:  w = '{H_OUT,  1'b0, 1'b0, 1'b0, 1'b1, C_MOREROW, STEP_MAC,  STEP_IDLE};
            default:    w = '{H_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,   STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* src/hcb_sequencer.sv */
module hcb_sequencer
    import hcb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_slot_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w;
    logic              go;
    logic              taken;

    assign w = ucode(r_step);

    always_comb begin
        case (w.hold)
            H_NONE:  go = 1'b1;
            H_IN:    go = i_in_valid;
            H_OUT:   go = i_slot_free;
            default: go = 1'b0;
        endcase
    end

    always_comb begin
        case (w.cond)
            C_NEVER:   taken = 1'b0;
            C_NOBLK:   taken = !i_stat.blk_done;
            C_MORECOL: taken = i_stat.more_col;
            C_MOREROW: taken = i_stat.more_row;
            default:   taken = 1'b0;
        endcase
    end

    always_comb begin
        if (!go) begin
            n_step = r_step;
        end else if (taken) begin
            n_step = w.tgt;
        end else begin
            n_step = w.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready     = (w.hold == H_IN);
    assign o_ctrl.load    = (w.hold == H_IN) && go;
    assign o_ctrl.clr     = ((w.hold == H_IN) || w.emit) && go;
    assign o_ctrl.mac     = w.mac;
    assign o_ctrl.acc_add = w.acc_add;
    assign o_ctrl.quot    = w.quot;
    assign o_ctrl.emit    = w.emit && go;

endmodule

/* src/hcb_datapath.sv */
module hcb_datapath
    import hcb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int IdxW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int CntW = $clog2(MAX_DIM + 1),
    localparam int RowW = SYM_W * MAX_DIM
)
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctrl                          i_ctrl,
    input  t_in                            i_in_data,
    input  logic [CntW-1:0]                i_dim,
    input  logic [MAX_DIM-1:0][RowW-1:0]   i_key,
    output t_stat                          o_stat,
    output t_out                           o_res
);

    localparam int ProdW = 2 * SYM_W;
    localparam int MaxP  = ((1 << SYM_W) - 1) * ((1 << SYM_W) - 1);
    localparam int AccW  = $clog2(MAX_DIM * MaxP + 1);
    localparam int QmW   = AccW + RECIP_W;
    localparam int QuoW  = QmW - RECIP_SH;

    logic [SYM_W-1:0] r_buf [MAX_DIM];
    logic [IdxW-1:0]  r_cnt;
    logic [CntW-1:0]  r_len;
    logic [IdxW-1:0]  r_i;
    logic [IdxW-1:0]  r_j;
    logic [ProdW-1:0] r_prod;
    logic [AccW-1:0]  r_acc;
    logic [QuoW-1:0]  r_quo;

    logic [CntW-1:0]  dim_m1;
    logic [CntW-1:0]  pos_n;
    logic [SYM_W-1:0] opnd;
    logic [SYM_W-1:0] kent;
    logic [ProdW-1:0] prod_n;
    logic [QmW-1:0]   qm;
    logic [AccW-1:0]  rem0;
    logic [AccW-1:0]  rem1;

    assign dim_m1 = i_dim - CntW'(1);
    assign pos_n  = CntW'(r_cnt) + CntW'(1);

    assign o_stat.blk_done = (pos_n >= i_dim) || i_in_data.end_of_message;
    assign o_stat.more_col = (CntW'(r_j) != dim_m1);
    assign o_stat.more_row = (CntW'(r_i) != dim_m1);

    // positions at or past the block length read as zero padding
    assign opnd   = (CntW'(r_j) < r_len) ? r_buf[r_j] : '0;
    assign kent   = i_key[r_i][r_j * SYM_W +: SYM_W];
    assign prod_n = ProdW'(kent) * ProdW'(opnd);

    assign qm   = QmW'(r_acc) * QmW'(RECIP);
    assign rem0 = r_acc - AccW'(AccW'(r_quo) * AccW'(MODULUS));
    assign rem1 = (rem0 >= AccW'(MODULUS)) ? rem0 - AccW'(MODULUS) : rem0;

    assign o_res.cipher_symbol = rem1[SYM_W-1:0];
    assign o_res.block_last    = !o_stat.more_row;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_buf[r_cnt] <= i_in_data.plain_symbol;
            if (o_stat.blk_done) begin
                r_len <= pos_n;
            end
        end
        if (i_ctrl.clr) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else begin
            if (i_ctrl.mac) begin
                r_prod <= prod_n;
            end
            if (i_ctrl.acc_add) begin
                r_acc <= r_acc + AccW'(r_prod);
            end
        end
        if (i_ctrl.quot) begin
            r_quo <= qm[QmW-1:RECIP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_i   <= '0;
            r_j   <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_cnt <= o_stat.blk_done ? '0 : pos_n[IdxW-1:0];
                r_i   <= '0;
            end else if (i_ctrl.emit && o_stat.more_row) begin
                r_i <= r_i + IdxW'(1);
            end
            if (i_ctrl.clr) begin
                r_j <= '0;
            end else if (i_ctrl.mac && o_stat.more_col) begin
                r_j <= r_j + IdxW'(1);
            end
        end
    end

endmodule

/* src/hill_cipher_block_mod26_core.sv */
// Hill cipher block over the alphabet 0..25.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one plaintext symbol
// per transfer. A symbol that does not close a block is stored and the
// block is ready again on the next cycle. A symbol that fills the block, or
// carries end_of_message, starts the block computation; missing positions
// are zero.
// Output channel (o_out_valid / i_out_ready / o_out_data): d cipher symbols
// per block, d = effective dimension, block_last set on the final one.
// Each result is computed on the single 5x5 multiply-accumulate unit in
// multiply steps along the key row, then a drain, a quotient and an emit
// step; the block takes no new input until its last result is emitted.
// The microprogram waits in its emit step while a finished result is held
// by a stalled receiver.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data, index 0 = dimension,
// 1..MAX_DIM = key rows. Write only while idle.
// Reset (synchronous, i_rst_n low): dimension 1, key zero, empty block,
// no result pending.
module hill_cipher_block_mod26_core
    import hcb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CntW = $clog2(MAX_DIM + 1);
    localparam int RowW = SYM_W * MAX_DIM;
    localparam logic [DIM_W-1:0] MaxDim3 = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]               r_dim;
    logic [MAX_DIM-1:0][RowW-1:0]   r_key;
    logic                           r_out_valid;
    t_out                           r_out;

    logic [DIM_W-1:0] dim_clamp;
    logic [CntW-1:0]  dim_eff;
    logic             slot_free;
    t_ctrl            ctrl;
    t_stat            stat;
    t_out             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_W'(1);
            r_key <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DIM) begin
                r_dim <= i_cfg_data[DIM_W-1:0];
            end
            for (int r = 0; r < MAX_DIM; r++) begin
                if (i_cfg_idx == CFG_IDX_W'(CFG_KEY0 + r)) begin
                    r_key[r] <= i_cfg_data[RowW-1:0];
                end
            end
        end
    end

    // zero acts as one, anything above the maximum acts as the maximum
    assign dim_clamp = (r_dim == '0) ? DIM_W'(1) : ((r_dim > MaxDim3) ? MaxDim3 : r_dim);
    assign dim_eff   = CntW'(dim_clamp);

    assign slot_free = !r_out_valid || i_out_ready;

    hcb_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_slot_free (slot_free),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_ctrl      (ctrl)
    );

    hcb_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_in_data (i_in_data),
        .i_dim     (dim_eff),
        .i_key     (r_key),
        .o_stat    (stat),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> slot_free)
        else $error("result loaded while previous one still pending");

    a_load_emit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.load |-> !ctrl.emit)
        else $error("input transfer and result load in the same step");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.emit && !stat.more_row) |=> o_in_ready)
        else $error("input not ready after last result of block");
`endif

endmodule
